/* hdl/sdf_pkg.sv */
// Shared types, constants and helpers for the sync word deframer.
`default_nettype none

package sdf_pkg;

  localparam int unsigned MAX_VALUES_DEF = 32;

  localparam logic [31:0] SYNC_DATA   = 32'hCAFED00D;
  localparam logic [31:0] SYNC_CONFIG = 32'hCAFEDECA;
  localparam logic [31:0] SYNC_DESCR  = 32'hDEADBEEF;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_CFG    = 2'd1;
  localparam logic [1:0] KIND_DSC    = 2'd2;

  typedef enum logic [2:0] {
    M_HUNT     = 3'd0,
    M_DATA_LEN = 3'd1,
    M_DATA_PAY = 3'd2,
    M_CFG_LEN  = 3'd3,
    M_CFG_PAY  = 3'd4,
    M_DSC_LEN  = 3'd5,
    M_DSC_PAY  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_RUN = 2'd0,
    SEQ_RD  = 2'd1,
    SEQ_LD  = 2'd2
  } seq_t;

  typedef enum logic [2:0] {
    HIT_MISS      = 3'd0,
    HIT_STEP_DATA = 3'd1,
    HIT_STEP_CFG  = 3'd2,
    HIT_STEP_DSC  = 3'd3,
    HIT_DATA      = 3'd4,
    HIT_CFG       = 3'd5,
    HIT_DSC       = 3'd6
  } hit_t;

  typedef struct packed {
    logic  take;
    mode_t mode;
    logic  emit_rd;
    logic  emit_ld;
  } cmd_t;

  typedef struct packed {
    hit_t hit;
    logic len_done;
    logic len_zero;
    logic len_big;
    logic pay_end;
    logic pend_run;
    logic emit_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] sync_byte(input logic [31:0] word, input logic [1:0] idx);
    sync_byte = 8'(word >> {idx, 3'b000});
  endfunction

endpackage

`default_nettype wire

/* hdl/sync_word_length_prefixed_deframer.sv */
// Top level of the sync word, length prefixed frame deframer.
`default_nettype none

// Takes one received byte per transfer and hunts for three little-endian sync
// words (data 0xCAFED00D, config 0xCAFEDECA, description 0xDEADBEEF), each
// followed by a 4-byte little-endian length and the payload. Config and
// description payload bytes leave as they arrive (tuser 1 or 2, tlast on the
// final byte). A data payload of up to MAX_VALUES words is kept in a RAM and
// sent out as a run of 32-bit words (tuser 0, tlast on the final word) when
// the next sync word completes, unless a stray byte comes first. A byte is
// accepted whenever no sample is being read out and the output register is
// free or being drained. A released sample pauses input while each word is read
// from the registered RAM and then loaded into the output register once free.
module sync_word_length_prefixed_deframer #(
  parameter int unsigned MAX_VALUES = sdf_pkg::MAX_VALUES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] payload
  output logic [1:0]       m_axis_tuser,  // [1:0] kind
  output logic             m_axis_tlast
);
  import sdf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sdf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sdf_datapath #(
    .MAX_VALUES(MAX_VALUES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (s_axis_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_kind (m_axis_tuser),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* hdl/sdf_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module sdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/sdf_ctrl.sv */
// Controller: frame mode state machine and sample readout sequencer.
`default_nettype none

module sdf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sdf_pkg::sts_t sts,
  output sdf_pkg::cmd_t      cmd
);
  import sdf_pkg::*;

  mode_t mode, mode_next;
  seq_t  seq, seq_next;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_HUNT;
      seq  <= SEQ_RUN;
    end else begin
      mode <= mode_next;
      seq  <= seq_next;
    end
  end

  always_comb begin
    in_ready    = (seq == SEQ_RUN) && sts.out_free;
    take        = in_valid && in_ready;
    mode_next   = mode;
    seq_next    = seq;
    cmd.take    = take;
    cmd.mode    = mode;
    cmd.emit_rd = 1'b0;
    cmd.emit_ld = 1'b0;

    case (seq)
      SEQ_RD: begin
        cmd.emit_rd = 1'b1;
        seq_next    = SEQ_LD;
      end
      SEQ_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          seq_next    = sts.emit_last ? SEQ_RUN : SEQ_RD;
        end
      end
      default: begin
        seq_next = SEQ_RUN;
      end
    endcase

    if (take) begin
      case (mode)
        M_DATA_LEN: begin
          if (sts.len_done) begin
            mode_next = (sts.len_zero || sts.len_big) ? M_HUNT : M_DATA_PAY;
          end
        end
        M_CFG_LEN: begin
          if (sts.len_done) begin
            mode_next = sts.len_zero ? M_HUNT : M_CFG_PAY;
          end
        end
        M_DSC_LEN: begin
          if (sts.len_done) begin
            mode_next = sts.len_zero ? M_HUNT : M_DSC_PAY;
          end
        end
        M_DATA_PAY, M_CFG_PAY, M_DSC_PAY: begin
          if (sts.pay_end) begin
            mode_next = M_HUNT;
          end
        end
        default: begin
          case (sts.hit)
            HIT_DATA: mode_next = M_DATA_LEN;
            HIT_CFG:  mode_next = M_CFG_LEN;
            HIT_DSC:  mode_next = M_DSC_LEN;
            default:  mode_next = M_HUNT;
          endcase
          if ((sts.hit == HIT_DATA || sts.hit == HIT_CFG || sts.hit == HIT_DSC)
              && sts.pend_run) begin
            seq_next = SEQ_RD;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/sdf_datapath.sv */
// Datapath: sync matchers, length and byte counters, sample store, output register.
`default_nettype none

module sdf_datapath #(
  parameter int unsigned MAX_VALUES = sdf_pkg::MAX_VALUES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    in_byte,
  input  wire sdf_pkg::cmd_t cmd,
  output sdf_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_data,
  output logic               out_last
);
  import sdf_pkg::*;

  localparam int unsigned AW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int unsigned WCW   = $clog2(MAX_VALUES + 1);
  localparam logic [31:0] LIMIT = 32'(4 * MAX_VALUES);

  logic [1:0]     dm, cm, xm;
  logic [31:0]    cnt;
  logic [31:0]    flen;
  logic [23:0]    asm_word;
  logic           pending;
  logic [WCW-1:0] words;
  logic [WCW-1:0] ridx;
  logic [31:0]    len_full;
  logic [31:0]    rd_data;
  logic           wr_en;
  logic           load_byte;
  hit_t           hit;

  always_comb begin
    if (in_byte == sync_byte(SYNC_DATA, dm)) begin
      hit = (dm == 2'd3) ? HIT_DATA : HIT_STEP_DATA;
    end else if (in_byte == sync_byte(SYNC_CONFIG, cm)) begin
      hit = (cm == 2'd3) ? HIT_CFG : HIT_STEP_CFG;
    end else if (in_byte == sync_byte(SYNC_DESCR, xm)) begin
      hit = (xm == 2'd3) ? HIT_DSC : HIT_STEP_DSC;
    end else begin
      hit = HIT_MISS;
    end
  end

  assign len_full  = {in_byte, flen[23:0]};
  assign wr_en     = cmd.take && (cmd.mode == M_DATA_PAY) && (cnt[1:0] == 2'd3);
  assign load_byte = cmd.take && (cmd.mode == M_CFG_PAY || cmd.mode == M_DSC_PAY);

  always_comb begin
    sts.hit       = hit;
    sts.len_done  = (cnt[1:0] == 2'd3);
    sts.len_zero  = (len_full == 32'd0);
    sts.len_big   = (len_full > LIMIT);
    sts.pay_end   = ((cnt + 32'd1) == flen);
    sts.pend_run  = pending && (words != '0);
    sts.emit_last = ((ridx + WCW'(1)) == words);
    sts.out_free  = !out_valid || out_ready;
  end

  sdf_ram #(
    .WIDTH(32),
    .DEPTH(MAX_VALUES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt[AW+1:2]),
    .wr_data({in_byte, asm_word}),
    .rd_en  (cmd.emit_rd),
    .rd_addr(ridx[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dm      <= '0;
      cm      <= '0;
      xm      <= '0;
      cnt     <= '0;
      flen    <= '0;
      pending <= 1'b0;
      words   <= '0;
      ridx    <= '0;
    end else begin
      if (cmd.emit_ld) begin
        ridx <= ridx + WCW'(1);
      end
      if (cmd.take) begin
        case (cmd.mode)
          M_DATA_LEN, M_CFG_LEN, M_DSC_LEN: begin
            flen <= flen | (32'(in_byte) << {cnt[1:0], 3'b000});
            cnt  <= sts.len_done ? 32'd0 : cnt + 32'd1;
          end
          M_DATA_PAY: begin
            case (cnt[1:0])
              2'd0:    asm_word[7:0]   <= in_byte;
              2'd1:    asm_word[15:8]  <= in_byte;
              2'd2:    asm_word[23:16] <= in_byte;
              default: ;
            endcase
            if (sts.pay_end) begin
              cnt     <= '0;
              words   <= flen[WCW+1:2];
              pending <= 1'b1;
            end else begin
              cnt <= cnt + 32'd1;
            end
          end
          M_CFG_PAY, M_DSC_PAY: begin
            cnt <= sts.pay_end ? 32'd0 : cnt + 32'd1;
          end
          default: begin
            case (hit)
              HIT_STEP_DATA: dm <= dm + 2'd1;
              HIT_STEP_CFG:  cm <= cm + 2'd1;
              HIT_STEP_DSC:  xm <= xm + 2'd1;
              HIT_MISS: begin
                dm      <= '0;
                cm      <= '0;
                xm      <= '0;
                pending <= 1'b0;
              end
              default: begin
                dm      <= '0;
                cm      <= '0;
                xm      <= '0;
                cnt     <= '0;
                flen    <= '0;
                pending <= 1'b0;
                ridx    <= '0;
              end
            endcase
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_kind <= (cmd.mode == M_CFG_PAY) ? KIND_CFG : KIND_DSC;
      out_data <= 32'(in_byte);
      out_last <= sts.pay_end;
    end else if (cmd.emit_ld) begin
      out_kind <= KIND_SAMPLE;
      out_data <= rd_data;
      out_last <= sts.emit_last;
    end
  end

endmodule

`default_nettype wire

/* hdl/sdf_checker.sv */
// Port-level checks for the deframer, bound to the top level.
`default_nettype none

module sdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import sdf_pkg::*;

  // kind is always one of the three defined codes
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_SAMPLE || m_axis_tuser == KIND_CFG ||
                       m_axis_tuser == KIND_DSC))
    else $error("undefined output kind");

  // payload bytes carry zeros above bit 7
  a_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_SAMPLE) |-> (m_axis_tdata[31:8] == 24'd0))
    else $error("payload byte with upper bits set");

  // a stalled transfer holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("output changed while stalled");

  // no output right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind sync_word_length_prefixed_deframer sdf_checker u_sdf_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the sync word, length prefixed frame deframer.
`default_nettype none

module testbench;
  import sdf_pkg::*;

  localparam int MAXV = MAX_VALUES_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] payload;
    logic        last;
  } deframed_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int mismatch_count = 0;
  int bytes_taken = 0;

  // predicted deframer state
  mode_t       rx_mode = M_HUNT;
  logic [2:0]  data_hits = '0;
  logic [2:0]  cfg_hits = '0;
  logic [2:0]  dsc_hits = '0;
  logic [31:0] byte_cnt = '0;
  logic [31:0] frame_len = '0;
  logic        sample_held = 1'b0;
  logic [5:0]  sample_words = '0;
  logic [31:0] sample_ram [MAXV];

  deframed_t due_outputs [$];

  sync_word_length_prefixed_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // queue one predicted output transfer
  function automatic void add_due(input deframed_t item);
    due_outputs.insert(due_outputs.size(), item);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic  hit;
    mode_t nxt;
    logic  [31:0] widx;
    logic  lst;
    case (rx_mode)
      M_DATA_LEN, M_CFG_LEN, M_DSC_LEN: begin
        frame_len[{byte_cnt[1:0], 3'b000} +: 8] = b;
        byte_cnt++;
        if (byte_cnt == 32'd4) begin
          byte_cnt = '0;
          if (frame_len == 0 || (rx_mode == M_DATA_LEN && frame_len > 32'(4 * MAXV)))
            rx_mode = M_HUNT;
          else
            rx_mode = mode_t'(rx_mode + 3'd1);
        end
      end
      M_DATA_PAY: begin
        widx = byte_cnt >> 2;
        if (widx < MAXV)
          sample_ram[widx[4:0]][{byte_cnt[1:0], 3'b000} +: 8] = b;
        byte_cnt++;
        if (byte_cnt >= frame_len) begin
          sample_words = 6'(frame_len >> 2);
          sample_held = 1'b1;
          byte_cnt = '0;
          rx_mode = M_HUNT;
        end
      end
      M_CFG_PAY, M_DSC_PAY: begin
        byte_cnt++;
        lst = (byte_cnt >= frame_len);
        add_due('{kind: (rx_mode == M_CFG_PAY) ? KIND_CFG : KIND_DSC,
                  payload: {24'd0, b}, last: lst});
        if (lst) begin
          byte_cnt = '0;
          rx_mode = M_HUNT;
        end
      end
      default: begin
        rx_mode = M_HUNT;
        hit = 1'b1;
        if (b == SYNC_DATA[{data_hits[1:0], 3'b000} +: 8]) begin
          data_hits++;
        end else if (b == SYNC_CONFIG[{cfg_hits[1:0], 3'b000} +: 8]) begin
          cfg_hits++;
        end else if (b == SYNC_DESCR[{dsc_hits[1:0], 3'b000} +: 8]) begin
          dsc_hits++;
        end else begin
          data_hits = '0;
          cfg_hits = '0;
          dsc_hits = '0;
          sample_held = 1'b0;
          hit = 1'b0;
        end
        if (hit) begin
          nxt = M_HUNT;
          if (data_hits >= 3'd4) nxt = M_DATA_LEN;
          else if (cfg_hits >= 3'd4) nxt = M_CFG_LEN;
          else if (dsc_hits >= 3'd4) nxt = M_DSC_LEN;
          if (nxt != M_HUNT) begin
            data_hits = '0;
            cfg_hits = '0;
            dsc_hits = '0;
            rx_mode = nxt;
            byte_cnt = '0;
            frame_len = '0;
            if (sample_held) begin
              for (int i = 0; i < int'(sample_words); i++)
                add_due('{kind: KIND_SAMPLE, payload: sample_ram[i],
                          last: (i + 1 == int'(sample_words))});
              sample_held = 1'b0;
              sample_words = '0;
            end
          end
        end
      end
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_taken++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[8 * k +: 8]);
  endtask

  task automatic wait_outputs_done();
    s_tvalid = 1'b0;
    while (due_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) m_tready = ($urandom_range(0, 99) >= sink_idle_pct);

  always @(posedge clk) begin
    deframed_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (due_outputs.size() == 0) begin
        $error("unexpected transfer: kind %0d payload %h last %b", m_tuser, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        want = due_outputs.pop_front();
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_tuser);
          mismatch_count++;
        end
        if (m_tdata !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed_frames();
    // data frame with a trailing odd byte, nothing pending yet
    send_word(SYNC_DATA);
    send_word(32'd5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h77);
    // description sync releases one word, zero length frame
    send_word(SYNC_DESCR);
    send_word(32'd0);
    // short data frame leaves an empty run pending
    send_word(SYNC_DATA);
    send_word(32'd2);
    send_byte(8'h11);
    send_byte(8'h22);
    send_word(SYNC_CONFIG);
    send_word(32'd1);
    send_byte(8'hFF);
    // oversized data length
    send_word(SYNC_DATA);
    send_word(32'(4 * MAXV + 1));
  endtask

  task automatic test_sync_priority();
    // config start is swallowed by the data word at its last byte
    send_byte(8'h0D);
    send_byte(8'hD0);
    send_byte(8'hFE);
    send_byte(8'hCA);
    send_word(32'd8);
    send_word(32'h89AB_CDEF);
    send_word(32'h0123_4567);
    // interleaved partial matches, config completes and flushes two words
    send_byte(8'h0D);
    send_word(SYNC_CONFIG);
    send_word(32'd3);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFE);
    // a full run of the largest size, dropped by a stray byte
    send_word(SYNC_DATA);
    send_word(32'(4 * MAXV));
    repeat (4 * MAXV) send_byte(8'($urandom));
    send_byte(8'h00);
    send_word(SYNC_DATA);
    send_word(32'(4 * MAXV));
    repeat (4 * MAXV) send_byte(8'($urandom));
    send_word(SYNC_DESCR);
    send_word(32'd2);
    send_byte(8'h3C);
    send_byte(8'hC3);
  endtask

  task automatic test_random_traffic(input int budget);
    int start;
    int pick;
    int sel;
    int n_pay;
    logic [31:0] len;
    logic [31:0] sync;
    start = bytes_taken;
    while (bytes_taken - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) len = $urandom_range(4, 24);
        else if (sel < 67) len = $urandom_range(1, 3);
        else if (sel < 74) len = 0;
        else if (sel < 77) len = 4 * MAXV;
        else if (sel < 83) len = $urandom_range(25, 4 * MAXV - 1);
        else if (sel < 91) len = $urandom_range(4 * MAXV + 1, 300);
        else len = $urandom | 32'h0000_0100;
        n_pay = (len != 0 && len <= 4 * MAXV) ? int'(len) : 0;
        send_word(SYNC_DATA);
        send_word(len);
        repeat (n_pay) send_byte(8'($urandom));
      end else if (pick < 82) begin
        len = $urandom_range(0, 6);
        send_word((pick < 65) ? SYNC_CONFIG : SYNC_DESCR);
        send_word(len);
        repeat (int'(len)) send_byte(8'($urandom));
      end else if (pick < 92) begin
        sel = $urandom_range(0, 2);
        sync = (sel == 0) ? SYNC_DATA : (sel == 1) ? SYNC_CONFIG : SYNC_DESCR;
        n_pay = $urandom_range(1, 3);
        for (int j = 0; j < n_pay; j++) send_byte(sync[8 * j +: 8]);
        send_byte(8'($urandom));
        send_byte(8'h00);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        send_byte(8'h00);
      end
    end
  endtask

  task automatic test_open_ended_config();
    // length with the top bit set never ends within the run
    send_byte(8'h00);
    send_word(SYNC_CONFIG);
    send_word({1'b1, 31'($urandom)});
    repeat (16) send_byte(8'($urandom));
  endtask

  initial begin
    for (int i = 0; i < MAXV; i++) sample_ram[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 27;
    sink_idle_pct = 77;
    test_directed_frames();
    wait_outputs_done();
    test_sync_priority();
    test_random_traffic(20);
    wait_outputs_done();

    src_idle_pct = 77;
    sink_idle_pct = 27;
    test_random_traffic(30);
    wait_outputs_done();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(30);
    test_open_ended_config();
    wait_outputs_done();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/sdf_pkg.sv
hdl/sdf_ram.sv
hdl/sdf_ctrl.sv
hdl/sdf_datapath.sv
hdl/sync_word_length_prefixed_deframer.sv
hdl/sdf_checker.sv
tb/sv/testbench.sv
